/* rtl/afce_pkg.sv */
// Shared types and constants for the ADC frame channel extractor.
`timescale 1ns / 1ps

package afce_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned MaxBytesW = 12;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned LeftW    = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned OutDataW = 56;

  localparam logic [WordW-1:0]     SyncWord        = 32'hFFFF_FFFF;
  localparam logic [ChanW-1:0]     ChannelIdReset  = 8'd234;
  localparam logic [MaxBytesW-1:0] MaxFrameReset   = 12'd1500;

  localparam logic [CfgIdxW-1:0] CfgChannelId = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFrame  = 2'd1;

  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhHeader  = 4'b0010,
    PhCount   = 4'b0100,
    PhPayload = 4'b1000
  } phase_e;

  typedef struct packed {
    logic hit;         // current word is a payload word of the selected channel
    logic in_payload;  // parser sits in the payload phase
    logic left_zero;   // no payload words outstanding
  } parse_status_t;

endpackage

/* rtl/afce_parser.sv */
// Frame phase tracking and channel match for one word per cycle while step_i is high.
`timescale 1ns / 1ps

module afce_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [afce_pkg::WordW-1:0]         word_i,
  input  logic [afce_pkg::ChanW-1:0]         channel_id_i,
  input  logic [afce_pkg::MaxBytesW-1:0]     max_bytes_i,
  output afce_pkg::parse_status_t            status_o
);

  afce_pkg::phase_e                 phase_q, phase_d;
  logic [afce_pkg::LeftW-1:0]       left_q, left_d;
  logic [afce_pkg::LeftW-1:0]       left_dec;
  logic [afce_pkg::LeftW-1:0]       count_words;
  logic                             too_big;

  assign left_dec    = left_q - 1'b1;
  assign count_words = word_i[afce_pkg::LeftW+1:2];
  assign too_big     = word_i > {{(afce_pkg::WordW-afce_pkg::MaxBytesW){1'b0}}, max_bytes_i};

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    unique case (phase_q)
      afce_pkg::PhHunt: begin
        if (word_i == afce_pkg::SyncWord) phase_d = afce_pkg::PhHeader;
      end
      afce_pkg::PhHeader: begin
        phase_d = word_i[afce_pkg::WordW-1] ? afce_pkg::PhHunt : afce_pkg::PhCount;
      end
      afce_pkg::PhCount: begin
        if (too_big) begin
          phase_d = afce_pkg::PhHunt;
        end else begin
          left_d  = count_words;
          phase_d = (count_words != '0) ? afce_pkg::PhPayload : afce_pkg::PhHunt;
        end
      end
      afce_pkg::PhPayload: begin
        left_d = left_dec;
        if (left_dec == '0) phase_d = afce_pkg::PhHunt;
      end
      default: phase_d = afce_pkg::PhHunt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= afce_pkg::PhHunt;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  assign status_o.hit        = (phase_q == afce_pkg::PhPayload) &&
                               (word_i[afce_pkg::WordW-1 -: afce_pkg::ChanW] == channel_id_i);
  assign status_o.in_payload = (phase_q == afce_pkg::PhPayload);
  assign status_o.left_zero  = (left_q == '0);

endmodule

/* rtl/adc_frame_channel_extractor_top.sv */
// Top level of the ADC frame channel extractor.
// Usage:
//   s_axis carries the capture stream, one 32-bit word per item. The block
//   hunts for the sync word, reads a header and a byte count, then passes
//   count/4 payload words through a channel filter.
//   m_axis carries one item per payload word whose top byte equals
//   channel_id: the raw word and its low 24 bits as a signed sample.
//   cfg_we_i / cfg_idx_i / cfg_data_i write channel_id (index 0) and
//   max_frame_bytes (index 1); other indices are ignored.
// Timing:
//   A word is registered on acceptance and parsed from the input register;
//   a matching word's result is then registered into the result register.
//   Throughput is one word per cycle while m_axis is not stalled, set by the
//   single input register and the single result register.
// Reset:
//   Registers return to channel 234 and a 1500 byte limit; the parser
//   restarts hunting and both register stages are emptied.
// Stall:
//   While m_axis is stalled a held result stays put; the input register
//   keeps taking words until a word must wait behind the held result.
`timescale 1ns / 1ps

module adc_frame_channel_extractor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [afce_pkg::WordW-1:0]        s_axis_tdata,   // [31:0] word
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [afce_pkg::OutDataW-1:0]     m_axis_tdata,   // [31:0] raw_word, [55:32] sample
  input  logic                              cfg_we_i,
  input  logic [afce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [afce_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [afce_pkg::ChanW-1:0]     channel_id_q;
  logic [afce_pkg::MaxBytesW-1:0] max_bytes_q;

  logic                           in_vld_q;
  logic [afce_pkg::WordW-1:0]     in_word_q;
  logic                           out_vld_q;
  logic [afce_pkg::OutDataW-1:0]  out_data_q;
  logic                           advance;
  afce_pkg::parse_status_t        status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_id_q <= afce_pkg::ChannelIdReset;
      max_bytes_q  <= afce_pkg::MaxFrameReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afce_pkg::CfgChannelId: channel_id_q <= cfg_data_i[afce_pkg::ChanW-1:0];
        afce_pkg::CfgMaxFrame:  max_bytes_q  <= cfg_data_i[afce_pkg::MaxBytesW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_word_q <= s_axis_tdata;
  end

  afce_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .word_i       (in_word_q),
    .channel_id_i (channel_id_q),
    .max_bytes_i  (max_bytes_q),
    .status_o     (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= advance && status.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && status.hit) begin
      out_data_q <= {in_word_q[afce_pkg::SampleW-1:0], in_word_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // A fresh result only comes from a matching word that just left the input stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(advance && status.hit))
    else $error("result appeared without a matching word");

  // The payload phase always has words outstanding.
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.in_payload |-> !status.left_zero)
    else $error("payload phase with zero words left");

  // A word blocked behind a held result stays in the input stage.
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_word_q)))
    else $error("stalled input word lost");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for the ADC frame channel extractor.
`timescale 1ns / 1ps

module testbench;

  localparam logic [afce_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [afce_pkg::WordW-1:0]          raw;
    logic signed [afce_pkg::SampleW-1:0] sample;
  } chan_sample_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [afce_pkg::WordW-1:0]        s_axis_tdata = '0;     // [31:0] word
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [afce_pkg::OutDataW-1:0]     m_axis_tdata;          // [31:0] raw_word, [55:32] sample
  logic                              cfg_we_i = 1'b0;
  logic [afce_pkg::CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [afce_pkg::CfgDataW-1:0]     cfg_data_i = '0;

  // predictor state and register copies
  afce_pkg::phase_e                  parse_phase = afce_pkg::PhHunt;
  logic [afce_pkg::LeftW-1:0]        words_due = '0;
  logic [afce_pkg::ChanW-1:0]        chan_cfg = afce_pkg::ChannelIdReset;
  logic [afce_pkg::MaxBytesW-1:0]    max_bytes_cfg = afce_pkg::MaxFrameReset;

  logic [afce_pkg::WordW-1:0]        capture_q[$];
  chan_sample_t                      due_samples[$];
  int                                capture_pending = 0;
  int                                words_queued = 0;
  int                                mismatch_count = 0;
  int                                tx_gap_pct = 0;
  int                                rx_stall_pct = 0;
  int                                tx_gap_left = 0;
  int                                rx_stall_left = 0;
  int unsigned                       quiet_cycles = 0;

  adc_frame_channel_extractor_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    mismatch_count++;
  endtask

  // advance the deframer by one accepted word
  function automatic void deframe_word(input logic [afce_pkg::WordW-1:0] w);
    chan_sample_t hit;
    case (parse_phase)
      afce_pkg::PhHunt: begin
        if (w == afce_pkg::SyncWord) parse_phase = afce_pkg::PhHeader;
      end
      afce_pkg::PhHeader: begin
        parse_phase = w[31] ? afce_pkg::PhHunt : afce_pkg::PhCount;
      end
      afce_pkg::PhCount: begin
        if (w > max_bytes_cfg) begin
          parse_phase = afce_pkg::PhHunt;
        end else begin
          words_due = w[11:2];
          parse_phase = (w[11:2] != '0) ? afce_pkg::PhPayload : afce_pkg::PhHunt;
        end
      end
      default: begin
        if (w[31:24] == chan_cfg) begin
          hit.raw = w;
          hit.sample = w[afce_pkg::SampleW-1:0];
          due_samples.push_back(hit);
        end
        words_due = words_due - 1'b1;
        if (words_due == '0) parse_phase = afce_pkg::PhHunt;
      end
    endcase
  endfunction

  // word driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_word(s_axis_tdata);
        capture_pending--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (capture_q.size() != 0) begin
          s_axis_tdata <= capture_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 99) < tx_gap_pct) tx_gap_left <= pick_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sample monitor
  always @(posedge clk_i) begin : sample_mon
    chan_sample_t due;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_samples.size() == 0) begin
          report_mismatch($sformatf("sample with none due: %h", m_axis_tdata));
        end else begin
          due = due_samples.pop_front();
          if (m_axis_tdata[31:0] !== due.raw)
            report_mismatch($sformatf("raw_word %h, want %h", m_axis_tdata[31:0], due.raw));
          if (m_axis_tdata[55:32] !== due.sample)
            report_mismatch($sformatf("sample %0d, want %0d",
                                      $signed(m_axis_tdata[55:32]), due.sample));
        end
      end
      if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) rx_stall_left <= pick_len();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t ERROR no item moved for %0d cycles", $time, QuietLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic put_word(input logic [afce_pkg::WordW-1:0] w);
    capture_q.push_back(w);
    capture_pending++;
    words_queued++;
  endtask

  task automatic put_frame(input logic [afce_pkg::WordW-1:0] header, input int count,
                           input int n_payload);
    put_word(afce_pkg::SyncWord);
    put_word(header);
    put_word(count);
    for (int i = 0; i < n_payload; i++) begin
      if ($urandom_range(0, 19) == 0) put_word(afce_pkg::SyncWord);
      else if ($urandom_range(0, 1) == 1) put_word({chan_cfg, 24'($urandom)});
      else put_word($urandom);
    end
  endtask

  task automatic write_reg(input logic [afce_pkg::CfgIdxW-1:0] idx,
                           input logic [afce_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == afce_pkg::CfgChannelId) chan_cfg = value[afce_pkg::ChanW-1:0];
    else if (idx == afce_pkg::CfgMaxFrame) max_bytes_cfg = value;
  endtask

  // hold off until every word is taken and every sample has arrived
  task automatic drain();
    do @(posedge clk_i); while (capture_pending != 0 || due_samples.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_burst(input int n_words);
    int stop_at;
    int pick;
    int count;
    logic [afce_pkg::WordW-1:0] header;
    stop_at = words_queued + n_words;
    while (words_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        header = $urandom & 32'h7FFF_FFFF;
        if (pick == 5) header = '0;
        if (pick == 6) header = 32'h7FFF_FFFF;
        count = $urandom_range(0, (max_bytes_cfg < 64) ? int'(max_bytes_cfg) : 64);
        if (pick < 3) count = $urandom_range(0, int'(max_bytes_cfg));
        put_frame(header, count, count >> 2);
      end else if (pick < 80) begin
        put_frame($urandom | 32'h8000_0000, $urandom_range(0, 64), $urandom_range(0, 8));
      end else if (pick < 88 && max_bytes_cfg != 12'hFFF) begin
        put_frame($urandom & 32'h7FFF_FFFF, $urandom_range(int'(max_bytes_cfg) + 1, 4095),
                  $urandom_range(0, 8));
      end else begin
        repeat ($urandom_range(1, 4))
          put_word(($urandom_range(0, 9) == 0) ? afce_pkg::SyncWord : $urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, no idling
    put_word(32'h0000_0000);
    put_word(32'hEA00_0001);
    put_word(afce_pkg::SyncWord);
    put_word(32'h7FFF_FFFF);
    put_word(32'd12);
    put_word(32'hEA80_0000);
    put_word(32'hEA7F_FFFF);
    put_word(afce_pkg::SyncWord);
    put_word(afce_pkg::SyncWord);
    put_word(32'h8000_0000);
    put_word(afce_pkg::SyncWord);
    put_word(afce_pkg::SyncWord);
    put_word(afce_pkg::SyncWord);
    put_word(32'h0000_0000);
    put_word(32'd3);
    put_word(afce_pkg::SyncWord);
    put_word(32'h0000_0000);
    put_word(32'd1501);
    put_word(afce_pkg::SyncWord);
    put_word(32'h0000_0000);
    put_word(32'd8);
    put_word(32'hEA00_0000);
    put_word(32'hEAFF_FFFF);
    drain();

    // widest limit, channel tag of all ones, ignored index
    write_reg(afce_pkg::CfgChannelId, 12'hFFF);
    write_reg(afce_pkg::CfgMaxFrame, 12'hFFF);
    write_reg(CfgSpare, 12'h5A5);
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    put_frame(32'h0000_0000, 403, 100);
    drain();

    // zero limit: only an empty frame is accepted
    write_reg(afce_pkg::CfgChannelId, 12'h000);
    write_reg(afce_pkg::CfgMaxFrame, 12'h000);
    tx_gap_pct = 60;
    rx_stall_pct = 60;
    put_frame(32'h0000_0000, 0, 0);
    put_frame(32'h0000_0000, 1, 0);
    random_burst(60);
    drain();

    for (int k = 0; k < 4; k++) begin
      write_reg(afce_pkg::CfgChannelId,
                (k == 2) ? 12'(afce_pkg::ChannelIdReset) : 12'($urandom));
      write_reg(afce_pkg::CfgMaxFrame, (k == 2) ? 12'd4 : 12'($urandom));
      tx_gap_pct = (k == 1) ? 0 : 20 + 15 * k;
      rx_stall_pct = (k == 1) ? 0 : 20 + 10 * k;
      random_burst(80);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/afce_pkg.sv
rtl/afce_parser.sv
rtl/adc_frame_channel_extractor_top.sv
bench/testbench.sv
